// File: src/cdq_pkg.sv
// Shared types and codes for the circular deque.
`timescale 1ns / 1ps
`default_nettype none
package cdq_pkg;

   localparam int unsigned WORD_W = 32;

   typedef logic signed [WORD_W-1:0] cdq_word_type;

   // Request kinds.
   localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
   localparam logic [1:0] KIND_PUSH_REAR  = 2'd1;
   localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
   localparam logic [1:0] KIND_POP_REAR   = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Command broadcast to every cell; at most one bit is set.
   typedef struct packed {
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
   } cdq_cmd_type;

endpackage
`default_nettype wire

// File: src/circular_deque.sv
// Top level of the double-ended queue built as a chain of word cells.
// Usage: each request word on the req_ channel asks for one of four operations,
// chosen by req_tuser: push at the front, push at the rear, pop from the front
// or pop from the rear. req_tdata carries the word to push; pops ignore it.
// Every request produces exactly one result word on the rsp_ channel with the
// status in rsp_tuser and, in rsp_tdata, the removed word, the front and rear
// words after the operation (zero when empty) and the count held.
// The words live in a row of DEPTH cells: the front is always cell 0 and the
// rear is the last occupied cell. A push at the front shifts the whole row one
// cell toward the rear, a pop from the front shifts it back. On acceptance
// the cells update and the state moves to ST_CALC, which reads the rear word
// through the one-hot select over the row into the output register. One
// request is in flight at a time, so no new request is taken until the
// previous result has been loaded into the output register.
// A push when full or a pop when empty changes nothing and reports so.
// Reset empties the deque and drops any pending result. When the receiver
// stalls the result holds in the output register; a new request can be taken
// in the same cycle the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none
module circular_deque #(
   parameter int unsigned DEPTH = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,   // [31:0] value
   input  wire logic [1:0]    req_tuser,   // [1:0] kind
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [103:0]       rsp_tdata,   // [31:0] removed_value, [63:32] front_value,
                                           // [95:64] rear_value, [99:96] count
   output logic [1:0]         rsp_tuser    // [1:0] status
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      ST_WAIT,
      ST_CALC
   } state_type;

   state_type state_ff;

   logic [CNT_W-1:0] count_ff, count_in;

   cdq_pkg::cdq_word_type cell_data [DEPTH];
   logic                  cell_occ  [DEPTH];
   logic                  cell_last [DEPTH];

   cdq_pkg::cdq_cmd_type  cmd;
   cdq_pkg::cdq_word_type push_value;
   cdq_pkg::cdq_word_type rear_now;
   cdq_pkg::cdq_word_type front_now;

   logic       accept;
   logic       is_push;
   logic       is_full;
   logic       is_empty;
   logic [1:0] status_in;
   cdq_pkg::cdq_word_type removed_in;

   // Held between the update cycle and the output load.
   logic [1:0]            status_ff;
   cdq_pkg::cdq_word_type removed_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   cdq_pkg::cdq_word_type rsp_removed_ff;
   cdq_pkg::cdq_word_type rsp_front_ff;
   cdq_pkg::cdq_word_type rsp_rear_ff;
   logic [3:0]            rsp_count_ff;

   assign push_value = cdq_pkg::cdq_word_type'(req_tdata);

   assign req_tready = (state_ff == ST_WAIT) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign is_push  = (req_tuser == cdq_pkg::KIND_PUSH_FRONT) ||
                     (req_tuser == cdq_pkg::KIND_PUSH_REAR);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Rear word: the single cell flagged as last, zero when the deque is empty.
   always_comb begin
      rear_now = '0;
      for (int i = 0; i < int'(DEPTH); i++) begin
         rear_now = rear_now | (cell_last[i] ? cell_data[i] : '0);
      end
   end

   assign front_now = cell_occ[0] ? cell_data[0] : '0;

   // Decode the request into a cell command; refused requests leave cells alone.
   always_comb begin
      cmd        = '0;
      status_in  = cdq_pkg::STATUS_DONE;
      removed_in = '0;
      count_in   = count_ff;
      if (accept) begin
         if (is_push && is_full) begin
            status_in = cdq_pkg::STATUS_FULL;
         end else if (!is_push && is_empty) begin
            status_in = cdq_pkg::STATUS_EMPTY;
         end else begin
            unique case (req_tuser)
               cdq_pkg::KIND_PUSH_FRONT: begin
                  cmd.push_front = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
               end
               cdq_pkg::KIND_PUSH_REAR: begin
                  cmd.push_rear = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
               end
               cdq_pkg::KIND_POP_FRONT: begin
                  cmd.pop_front = 1'b1;
                  removed_in    = cell_data[0];
                  count_in      = count_ff - CNT_W'(1);
               end
               cdq_pkg::KIND_POP_REAR: begin
                  cmd.pop_rear = 1'b1;
                  removed_in   = rear_now;
                  count_in     = count_ff - CNT_W'(1);
               end
               default: begin
                  cmd = '0;
               end
            endcase
         end
      end
   end

   // The row of cells. Cell 0 sees the incoming word as its left neighbor,
   // marked occupied, so front pushes enter there; the last cell sees an empty
   // right neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cdq_pkg::cdq_word_type left_data;
      logic                  left_occ;
      cdq_pkg::cdq_word_type right_data;
      logic                  right_occ;

      if (i == 0) begin : g_first
         assign left_data = push_value;
         assign left_occ  = 1'b1;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
         assign left_occ  = cell_occ[i-1];
      end

      if (i == DEPTH - 1) begin : g_final
         assign right_data = '0;
         assign right_occ  = 1'b0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
         assign right_occ  = cell_occ[i+1];
      end

      cdq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .value      (push_value),
         .left_data  (left_data),
         .left_occ   (left_occ),
         .right_data (right_data),
         .right_occ  (right_occ),
         .data       (cell_data[i]),
         .occ        (cell_occ[i]),
         .last       (cell_last[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_WAIT: begin
               if (accept) begin
                  status_ff  <= status_in;
                  removed_ff <= removed_in;
                  state_ff   <= ST_CALC;
               end
            end
            ST_CALC: begin
               // Cells now hold the post-operation contents.
               rsp_valid_ff   <= 1'b1;
               rsp_status_ff  <= status_ff;
               rsp_removed_ff <= removed_ff;
               rsp_front_ff   <= front_now;
               rsp_rear_ff    <= rear_now;
               rsp_count_ff   <= 4'(count_ff);
               state_ff       <= ST_WAIT;
            end
            default: begin
               state_ff <= ST_WAIT;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_rear_ff, rsp_front_ff, rsp_removed_ff};

endmodule
`default_nettype wire

// File: src/cdq_cell.sv
// One cell of the deque chain: a word, its occupied flag, and the shift rules.
`timescale 1ns / 1ps
`default_nettype none
module cdq_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cdq_pkg::cdq_cmd_type  cmd,
   input  wire cdq_pkg::cdq_word_type value,
   input  wire cdq_pkg::cdq_word_type left_data,
   input  wire logic                 left_occ,
   input  wire cdq_pkg::cdq_word_type right_data,
   input  wire logic                 right_occ,
   output cdq_pkg::cdq_word_type     data,
   output logic                      occ,
   output logic                      last
);

   cdq_pkg::cdq_word_type data_ff, data_in;
   logic                  occ_ff, occ_in;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      if (cmd.push_front) begin
         // Everything moves one cell toward the rear.
         data_in = left_data;
         occ_in  = left_occ;
      end else if (cmd.push_rear) begin
         // The first free cell takes the new word.
         if (!occ_ff && left_occ) begin
            data_in = value;
            occ_in  = 1'b1;
         end
      end else if (cmd.pop_front) begin
         data_in = right_data;
         occ_in  = right_occ;
      end else if (cmd.pop_rear) begin
         if (occ_ff && !right_occ) begin
            occ_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign occ  = occ_ff;
   assign last = occ_ff && !right_occ;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the circular deque: directed table, then random push/pop bursts.
`timescale 1ns / 1ps
module testbench;

   localparam int DEPTH        = 8;
   localparam int RANDOM_WORDS = 1100;
   localparam int HOLD_AFTER   = 300;    // results seen before the long receiver hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PRINT_LIMIT  = 25;

   typedef struct packed {
      logic [1:0]            status;
      cdq_pkg::cdq_word_type removed;
      cdq_pkg::cdq_word_type front;
      cdq_pkg::cdq_word_type rear;
      logic [3:0]            count;
   } deque_result_type;

   typedef struct packed {
      logic [1:0]            kind;
      cdq_pkg::cdq_word_type value;
      logic                  pinned;   // expected result typed in below
      deque_result_type      want;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [31:0]   req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [103:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;

   // Travels alongside each request word so the monitor knows which expectation to queue.
   logic             pin_enable;
   deque_result_type pin_result;

   deque_result_type outstanding_results[$];
   int            mismatches      = 0;
   int            requests_taken  = 0;
   int            results_checked = 0;
   int            full_refusals   = 0;
   int            empty_refusals  = 0;
   int            cycles          = 0;

   // Mirror of the deque contents.
   cdq_pkg::cdq_word_type held_words[DEPTH];
   int            front_ix   = 0;
   int            rear_ix    = 0;
   int            held_total = 0;

   // Empty pops, a lone word pushed and popped at both extremes, a fill with wrap at the
   // front, pushes refused when full, a drain from both ends and pushes into an empty deque.
   stim_row_type directed_rows [0:24] = '{
      '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b1,
        '{cdq_pkg::STATUS_EMPTY, 32'h0, 32'h0, 32'h0, 4'd0}},
      '{cdq_pkg::KIND_POP_REAR,   32'hFFFF_FFFF, 1'b1,
        '{cdq_pkg::STATUS_EMPTY, 32'h0, 32'h0, 32'h0, 4'd0}},
      '{cdq_pkg::KIND_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
        '{cdq_pkg::STATUS_DONE, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd1}},
      '{cdq_pkg::KIND_POP_REAR,   32'h1234_5678, 1'b1,
        '{cdq_pkg::STATUS_DONE, 32'h7FFF_FFFF, 32'h0, 32'h0, 4'd0}},
      '{cdq_pkg::KIND_PUSH_REAR,  32'h8000_0000, 1'b1,
        '{cdq_pkg::STATUS_DONE, 32'h0, 32'h8000_0000, 32'h8000_0000, 4'd1}},
      '{cdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_REAR,  32'h0000_0000, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_REAR,  32'h5555_5555, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_REAR,  32'h0F0F_0F0F, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_REAR,  32'h1234_5678, 1'b1,
        '{cdq_pkg::STATUS_FULL, 32'h0, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 4'd8}},
      '{cdq_pkg::KIND_PUSH_FRONT, 32'h8765_4321, 1'b1,
        '{cdq_pkg::STATUS_FULL, 32'h0, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 4'd8}},
      '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, '0},
      '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b0, '0},
      '{cdq_pkg::KIND_POP_FRONT,  32'hFFFF_FFFF, 1'b0, '0},
      '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b0, '0},
      '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b0, '0},
      '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b0, '0},
      '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, '0},
      '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, '0},
      '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b1,
        '{cdq_pkg::STATUS_EMPTY, 32'h0, 32'h0, 32'h0, 4'd0}},
      '{cdq_pkg::KIND_PUSH_FRONT, 32'h8000_0001, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_REAR,  32'h7FFF_FFFE, 1'b0, '0}
   };

   circular_deque #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Applies one request to the mirror and returns the result the block must give.
   function automatic deque_result_type apply_request(input logic [1:0] kind,
                                                      input cdq_pkg::cdq_word_type value);
      deque_result_type r;
      r = '0;
      r.status = cdq_pkg::STATUS_DONE;
      if (kind == cdq_pkg::KIND_PUSH_FRONT || kind == cdq_pkg::KIND_PUSH_REAR) begin
         if (held_total >= DEPTH) begin
            r.status = cdq_pkg::STATUS_FULL;
            full_refusals++;
         end else if (held_total == 0) begin
            // Either push into an empty deque restarts both ends at entry 0.
            front_ix = 0;
            rear_ix = 0;
            held_words[0] = value;
            held_total = 1;
         end else if (kind == cdq_pkg::KIND_PUSH_FRONT) begin
            front_ix = (front_ix == 0) ? DEPTH - 1 : front_ix - 1;
            held_words[front_ix] = value;
            held_total++;
         end else begin
            rear_ix = (rear_ix == DEPTH - 1) ? 0 : rear_ix + 1;
            held_words[rear_ix] = value;
            held_total++;
         end
      end else begin
         if (held_total == 0) begin
            r.status = cdq_pkg::STATUS_EMPTY;
            empty_refusals++;
         end else if (kind == cdq_pkg::KIND_POP_FRONT) begin
            r.removed = held_words[front_ix];
            if (held_total > 1) front_ix = (front_ix == DEPTH - 1) ? 0 : front_ix + 1;
            held_total--;
         end else begin
            r.removed = held_words[rear_ix];
            if (held_total > 1) rear_ix = (rear_ix == 0) ? DEPTH - 1 : rear_ix - 1;
            held_total--;
         end
      end
      if (held_total != 0) begin
         r.front = held_words[front_ix];
         r.rear = held_words[rear_ix];
      end
      r.count = held_total[3:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   // Idle stretch length: mostly a few cycles, now and then a long one.
   function automatic int pick_idle();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   // Offers one request word after a gap and waits until it is taken.
   task automatic offer_word(input logic [1:0] kind, input cdq_pkg::cdq_word_type value,
                             input logic pinned, input deque_result_type want,
                             input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= $urandom;
         req_tuser <= 2'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= value;
      pin_enable <= pinned;
      pin_result <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // Queues an expectation for every request taken and checks every result taken.
   always @(posedge clock) begin : monitor
      deque_result_type want;
      deque_result_type model;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            model = apply_request(req_tuser, req_tdata);
            outstanding_results.push_back(pin_enable ? pin_result : model);
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (outstanding_results.size() == 0) begin
               report_mismatch("result word with nothing outstanding", rsp_tdata[31:0], 32'h0);
            end else begin
               want = outstanding_results.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[31:0] !== want.removed)
                  report_mismatch("removed word", rsp_tdata[31:0], want.removed);
               if (rsp_tdata[63:32] !== want.front)
                  report_mismatch("front word", rsp_tdata[63:32], want.front);
               if (rsp_tdata[95:64] !== want.rear)
                  report_mismatch("rear word", rsp_tdata[95:64], want.rear);
               if (rsp_tdata[99:96] !== want.count)
                  report_mismatch("count", 32'(rsp_tdata[99:96]), 32'(want.count));
            end
         end
      end
   end

   // Receiver: random stalls, calm stretches, and one long hold-off that backs up the block.
   initial begin : result_sink
      int stall_left;
      bit calm;
      bit hold_done;
      stall_left = 0;
      calm = 1'b0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 149) == 0) calm = !calm;
         if (!hold_done && results_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_idle();
         end
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("circular_deque: mismatch");
      $finish;
   end

   initial begin : stimulus
      int issued;
      int burst_len;
      int push_pct;
      bit calm;
      logic [1:0] kind;
      cdq_pkg::cdq_word_type value;
      issued = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = cdq_pkg::KIND_PUSH_FRONT;
      pin_enable = 1'b0;
      pin_result = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_word(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].pinned,
                    directed_rows[i].want, ($urandom_range(0, 2) == 0) ? pick_idle() : 0);

      // Bursts favor pushes, pops or neither, so the deque swings between full and empty.
      while (issued < RANDOM_WORDS) begin
         burst_len = $urandom_range(8, 48);
         case ($urandom_range(0, 2))
            0: begin
               push_pct = 80;
            end
            1: begin
               push_pct = 20;
            end
            default: begin
               push_pct = 50;
            end
         endcase
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < burst_len && issued < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 99) < push_pct)
               kind = $urandom_range(0, 1) ? cdq_pkg::KIND_PUSH_REAR : cdq_pkg::KIND_PUSH_FRONT;
            else
               kind = $urandom_range(0, 1) ? cdq_pkg::KIND_POP_REAR : cdq_pkg::KIND_POP_FRONT;
            case ($urandom_range(0, 15))
               0: begin
                  value = 32'h8000_0000;
               end
               1: begin
                  value = 32'h7FFF_FFFF;
               end
               2: begin
                  value = 32'h0;
               end
               3: begin
                  value = 32'hFFFF_FFFF;
               end
               default: begin
                  value = $urandom;
               end
            endcase
            offer_word(kind, value, 1'b0, '0,
                       (calm || $urandom_range(0, 99) < 60) ? 0 : pick_idle());
            issued++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests through the deque and checked %0d result words,",
               requests_taken, results_checked);
      $display("with %0d pushes refused as full and %0d pops refused as empty.",
               full_refusals, empty_refusals);
      if (mismatches == 0) begin
         $display("circular_deque: match");
      end else begin
         $display("circular_deque: mismatch");
      end
      $finish;
   end

endmodule
